### rtl/grain_envelope_window_top_defines.svh
// ----------------------------------------------------------------------------
// Grain envelope window assertion macros
// Assertion helpers shared by the grain envelope window RTL. In synthesis
// builds the macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef GRAIN_ENVELOPE_WINDOW_TOP_DEFINES_SVH
`define GRAIN_ENVELOPE_WINDOW_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property on every rising edge of clk outside of reset.
`define GEW_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("grain envelope window: property violated");

// Checks that a condition in one cycle is followed by another in the next.
`define GEW_ASSERT_NXT(label, cond, next_cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (next_cond)) \
    else $error("grain envelope window: next-cycle property violated");

`else

`define GEW_ASSERT(label, prop)
`define GEW_ASSERT_NXT(label, cond, next_cond)

`endif

`endif

### rtl/gew_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grain envelope window package
// Field widths, register and shape codes, the item class type and the
// function that builds the gaussian table entries.
// ----------------------------------------------------------------------------
package gew_pkg;

  localparam int GEW_GAUSS_DEPTH = 1024;

  localparam int POS_W      = 16;
  localparam int LEN_W      = 16;
  localparam int SHAPE_W    = 3;
  localparam int GAIN_W     = 16;
  localparam int QUO_W      = 31;
  localparam int POW_FRAC   = 30;
  localparam int GAIN_FRAC  = 15;
  localparam int NUM_W      = LEN_W + POW_FRAC;
  localparam int DEN_W      = LEN_W + 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WLEN  = 1'b1;

  localparam logic [SHAPE_W-1:0] SHAPE_GAUSS   = 3'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_TRI     = 3'd2;
  localparam logic [SHAPE_W-1:0] SHAPE_RECT    = 3'd3;
  localparam logic [SHAPE_W-1:0] SHAPE_PULSE   = 3'd4;
  localparam logic [SHAPE_W-1:0] SHAPE_REVERSE = 3'd5;

  localparam logic [SHAPE_W-1:0] SHAPE_RESET = SHAPE_GAUSS;
  localparam logic [LEN_W-1:0]   WLEN_RESET  = 16'd1024;
  localparam logic [GAIN_W-1:0]  GAIN_ONE    = 16'h8000;

  // How an item's gain is formed once the divide is done.
  typedef enum logic [2:0] {
    KIND_ZERO,
    KIND_GAUSS,
    KIND_TRI,
    KIND_RECT,
    KIND_POW
  } gew_kind_t;

  // exp(-64*s) in Q1.15 for s in Q31: Taylor sum of exp(-s), then six squarings.
  function automatic logic [GAIN_W-1:0] gauss_entry(input logic [63:0] s);
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] prod;
    logic [63:0] rnd;
    term = 64'd1 << 31;
    e    = 64'd1 << 31;
    for (int n = 1; n <= 12; n++) begin
      prod = (term * s) >> 31;
      unique case (n)
        1:       term = prod;
        2:       term = prod / 64'd2;
        3:       term = prod / 64'd3;
        4:       term = prod / 64'd4;
        5:       term = prod / 64'd5;
        6:       term = prod / 64'd6;
        7:       term = prod / 64'd7;
        8:       term = prod / 64'd8;
        9:       term = prod / 64'd9;
        10:      term = prod / 64'd10;
        11:      term = prod / 64'd11;
        default: term = prod / 64'd12;
      endcase
      if ((n & 1) == 1) begin
        e = (e >= term) ? e - term : 64'd0;
      end else begin
        e = e + term;
      end
    end
    if (e > (64'd1 << 31)) begin
      e = 64'd1 << 31;
    end
    for (int k = 0; k < 6; k++) begin
      e = (e * e) >> 31;
    end
    rnd = e + (64'd1 << 15);
    return rnd[GAIN_W+15:16];
  endfunction

endpackage

### rtl/gew_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grain envelope pipelined divider
// Restoring divider that settles one quotient bit per register stage and
// carries a sideband word alongside each item.
// ----------------------------------------------------------------------------
module gew_div import gew_pkg::*; #(
  parameter int NUM_WIDTH = NUM_W,
  parameter int DEN_WIDTH = DEN_W,
  parameter int QUO_WIDTH = QUO_W,
  parameter int SB_W      = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [NUM_WIDTH-1:0] in_num,
  input  logic [DEN_WIDTH-1:0] in_den,
  input  logic [SB_W-1:0]      in_sb,
  output logic                 out_valid,
  output logic [QUO_WIDTH-1:0] out_quo,
  output logic [DEN_WIDTH-1:0] out_rem,
  output logic [SB_W-1:0]      out_sb
);

  localparam int REM_W = DEN_WIDTH + QUO_WIDTH;

  logic                 valid_r   [QUO_WIDTH];
  logic [REM_W-1:0]     rem_r     [QUO_WIDTH];
  logic [QUO_WIDTH-1:0] quo_r     [QUO_WIDTH];
  logic [DEN_WIDTH-1:0] den_r     [QUO_WIDTH];
  logic [SB_W-1:0]      sb_r      [QUO_WIDTH];

  logic                 valid_in  [QUO_WIDTH];
  logic [REM_W-1:0]     rem_in    [QUO_WIDTH];
  logic [QUO_WIDTH-1:0] quo_in    [QUO_WIDTH];
  logic [DEN_WIDTH-1:0] den_in    [QUO_WIDTH];
  logic [SB_W-1:0]      sb_in     [QUO_WIDTH];

  logic [REM_W-1:0]     rem_nxt   [QUO_WIDTH];
  logic [QUO_WIDTH-1:0] quo_nxt   [QUO_WIDTH];

  for (genvar k = 0; k < QUO_WIDTH; k++) begin : g_stage
    localparam int B = QUO_WIDTH - 1 - k;

    if (k == 0) begin : g_first
      assign valid_in[k] = in_valid;
      assign rem_in[k]   = REM_W'(in_num);
      assign quo_in[k]   = '0;
      assign den_in[k]   = in_den;
      assign sb_in[k]    = in_sb;
    end else begin : g_next
      assign valid_in[k] = valid_r[k-1];
      assign rem_in[k]   = rem_r[k-1];
      assign quo_in[k]   = quo_r[k-1];
      assign den_in[k]   = den_r[k-1];
      assign sb_in[k]    = sb_r[k-1];
    end

    // Try to take the shifted divisor out of the partial remainder.
    always_comb begin
      logic [REM_W-1:0] trial;
      trial = REM_W'(den_in[k]) << B;
      if (rem_in[k] >= trial) begin
        rem_nxt[k] = rem_in[k] - trial;
        quo_nxt[k] = quo_in[k] | (QUO_WIDTH'(1) << B);
      end else begin
        rem_nxt[k] = rem_in[k];
        quo_nxt[k] = quo_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= valid_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
        den_r[k] <= den_in[k];
        sb_r[k]  <= sb_in[k];
      end
    end
  end

  assign out_valid = valid_r[QUO_WIDTH-1];
  assign out_quo   = quo_r[QUO_WIDTH-1];
  assign out_rem   = rem_r[QUO_WIDTH-1][DEN_WIDTH-1:0];
  assign out_sb    = sb_r[QUO_WIDTH-1];

endmodule

### rtl/gew_gauss_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grain envelope gaussian table
// Constant table of exp(-2*x^2) over |x| in [0,4), built at elaboration,
// with a registered read port.
// ----------------------------------------------------------------------------
module gew_gauss_rom import gew_pkg::*; #(
  parameter int DEPTH  = GEW_GAUSS_DEPTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [GAIN_W-1:0] rd_data
);

  logic [GAIN_W-1:0] rom_w [DEPTH];
  logic [GAIN_W-1:0] rd_data_r;

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_entry
    localparam logic [63:0] SVal =
      (64'(gi) * 64'(gi) * (64'd1 << 30)) / (64'(DEPTH) * 64'(DEPTH));
    assign rom_w[gi] = gauss_entry(SVal);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data_r <= rom_w[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/gew_pow5.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grain envelope fifth power chain
// Raises a Q30 fraction to the fifth power with one registered multiply per
// stage, then rounds to Q1.15.
// ----------------------------------------------------------------------------
module gew_pow5 import gew_pkg::*; #(
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [QUO_W-1:0]  in_q,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_valid,
  output logic [GAIN_W-1:0] out_gain,
  output logic [SB_W-1:0]   out_sb
);

  localparam int MULS = 4;

  logic              valid_r [MULS+1];
  logic [SB_W-1:0]   sb_r    [MULS+1];
  logic [QUO_W-1:0]  p_r     [MULS];
  logic [QUO_W-1:0]  q_r     [MULS];
  logic [GAIN_W-1:0] gain_r;

  logic [QUO_W-1:0]  p_in    [MULS];
  logic [QUO_W-1:0]  q_in    [MULS];
  logic [QUO_W-1:0]  p_nxt   [MULS];
  logic [QUO_W:0]    rnd;

  for (genvar k = 0; k < MULS; k++) begin : g_mul
    if (k == 0) begin : g_first
      assign p_in[k] = in_q;
      assign q_in[k] = in_q;
    end else begin : g_next
      assign p_in[k] = p_r[k-1];
      assign q_in[k] = q_r[k-1];
    end

    always_comb begin
      logic [2*QUO_W-1:0] prod;
      prod     = (2*QUO_W)'(p_in[k]) * (2*QUO_W)'(q_in[k]);
      p_nxt[k] = prod[QUO_W+POW_FRAC-1:POW_FRAC];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_r[k] <= p_nxt[k];
        q_r[k] <= q_in[k];
      end
    end
  end

  // Round half up from Q30 to Q15.
  assign rnd = (QUO_W+1)'(p_r[MULS-1]) + ((QUO_W+1)'(1) << (POW_FRAC - GAIN_FRAC - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= MULS; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (en) begin
      valid_r[0] <= in_valid;
      for (int i = 1; i <= MULS; i++) begin
        valid_r[i] <= valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= in_sb;
      for (int i = 1; i <= MULS; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
      gain_r <= rnd[GAIN_W+POW_FRAC-GAIN_FRAC-1:POW_FRAC-GAIN_FRAC];
    end
  end

  assign out_valid = valid_r[MULS];
  assign out_gain  = gain_r;
  assign out_sb    = sb_r[MULS];

endmodule

### rtl/grain_envelope_window_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grain envelope window
// Turns a window position into the grain envelope gain in unsigned Q1.15
// for one of five configured shapes.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Payload
//  in_       input      in_valid/in_stall   in_position  (16 bit)
//  out_      output     out_valid/out_stall out_gain     (16 bit, Q1.15)
//  cfg_      input      cfg_we              cfg_index, cfg_wdata
//
// One beat enters per cycle while in_stall is low. A beat's gain passes
// through 16 stages of the position modulo, one setup stage, 31 stages of
// the quotient divider, one table read stage, five stages of the fifth power
// chain and the output register. The divider's one quotient bit per stage
// sets that depth. Reset is synchronous and clears all valid bits and the
// configuration to gaussian shape and a 1024 sample window. A stalled output
// beat waits in the output register while the next one moves into a skid
// register; only when the skid register is full does in_stall rise, and the
// whole pipeline holds until the skid beat drains.
//
`include "grain_envelope_window_top_defines.svh"

module grain_envelope_window_top import gew_pkg::*; #(
  parameter int GAUSS_TABLE_DEPTH = GEW_GAUSS_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [POS_W-1:0]      in_position,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [GAIN_W-1:0]     out_gain,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W    = $clog2(GAUSS_TABLE_DEPTH);
  localparam int MOD_SB_W = SHAPE_W + LEN_W + POS_W;
  localparam int KIND_W   = $bits(gew_kind_t);
  localparam int POW_SB_W = GAIN_W + 1;

  // Configuration registers.
  logic [SHAPE_W-1:0] shape_r, shape_nxt;
  logic [LEN_W-1:0]   wlen_r, wlen_nxt;

  always_comb begin
    shape_nxt = shape_r;
    wlen_nxt  = wlen_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHAPE: shape_nxt = cfg_wdata[SHAPE_W-1:0];
        CFG_WLEN:  wlen_nxt  = cfg_wdata[LEN_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r <= SHAPE_RESET;
      wlen_r  <= WLEN_RESET;
    end else begin
      shape_r <= shape_nxt;
      wlen_r  <= wlen_nxt;
    end
  end

  // The whole pipeline advances together unless a beat sits in the skid register.
  logic skid_valid_r, skid_valid_nxt;
  logic en;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // Position modulo window length. The configuration rides along with the beat.
  logic               mod_valid;
  logic [LEN_W-1:0]   mod_rem;
  logic [MOD_SB_W-1:0] mod_sb;

  gew_div #(
    .NUM_WIDTH (POS_W),
    .DEN_WIDTH (LEN_W),
    .QUO_WIDTH (POS_W),
    .SB_W      (MOD_SB_W)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_num    (in_position),
    .in_den    (wlen_r),
    .in_sb     ({shape_r, wlen_r, in_position}),
    .out_valid (mod_valid),
    .out_quo   (),
    .out_rem   (mod_rem),
    .out_sb    (mod_sb)
  );

  // Setup: each shape reduces to one numerator over one denominator.
  // Gaussian:  |2*pos - len| * DEPTH / (4*len), the table index.
  // Triangle:  (span - |2*pos - span|) * 2^15 / span, with span = len - 1.
  // Pulses:    (len - m or m) * 2^30 / len, the Q30 base of the fifth power.
  logic [SHAPE_W-1:0] m_shape;
  logic [LEN_W-1:0]   m_len;
  logic [POS_W-1:0]   m_pos;

  assign {m_shape, m_len, m_pos} = mod_sb;

  logic [LEN_W:0]   two, len_x, gdist, span_x, tdist;
  logic [LEN_W+1:0] len4;
  logic [LEN_W-1:0] span, pnum;
  logic             far, tzero, len_zero;
  gew_kind_t        prep_kind;
  logic [NUM_W-1:0] prep_num;
  logic [DEN_W-1:0] prep_den;

  always_comb begin
    two      = (LEN_W+1)'({m_pos, 1'b0});
    len_x    = {1'b0, m_len};
    gdist    = (two >= len_x) ? two - len_x : len_x - two;
    len4     = {m_len, 2'b00};
    far      = (LEN_W+2)'(gdist) >= len4;
    span     = m_len - LEN_W'(1);
    span_x   = {1'b0, span};
    tdist    = (two >= span_x) ? two - span_x : span_x - two;
    tzero    = (m_len < LEN_W'(2)) || (tdist >= span_x);
    len_zero = (m_len == '0);
    pnum     = (m_shape == SHAPE_PULSE) ? m_len - mod_rem : mod_rem;

    prep_kind = KIND_ZERO;
    prep_num  = '0;
    prep_den  = '0;
    unique case (m_shape)
      SHAPE_GAUSS: begin
        prep_kind = (len_zero || far) ? KIND_ZERO : KIND_GAUSS;
        prep_num  = NUM_W'(gdist) * NUM_W'(GAUSS_TABLE_DEPTH);
        prep_den  = DEN_W'(len4);
      end
      SHAPE_TRI: begin
        prep_kind = tzero ? KIND_ZERO : KIND_TRI;
        prep_num  = NUM_W'(span - tdist[LEN_W-1:0]) << GAIN_FRAC;
        prep_den  = DEN_W'(span);
      end
      SHAPE_RECT: begin
        prep_kind = KIND_RECT;
      end
      SHAPE_PULSE, SHAPE_REVERSE: begin
        prep_kind = len_zero ? KIND_ZERO : KIND_POW;
        prep_num  = NUM_W'(pnum) << POW_FRAC;
        prep_den  = DEN_W'(m_len);
      end
      default: begin
        prep_kind = KIND_ZERO;
      end
    endcase
  end

  logic             prep_valid_r;
  logic [NUM_W-1:0] prep_num_r;
  logic [DEN_W-1:0] prep_den_r;
  gew_kind_t        prep_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
    end else if (en) begin
      prep_valid_r <= mod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_num_r  <= prep_num;
      prep_den_r  <= prep_den;
      prep_kind_r <= prep_kind;
    end
  end

  // Main divider. Every valid numerator stays below the denominator times 2^31.
  logic              div_valid;
  logic [QUO_W-1:0]  div_quo;
  logic [KIND_W-1:0] div_sb;
  gew_kind_t         div_kind;

  gew_div #(
    .NUM_WIDTH (NUM_W),
    .DEN_WIDTH (DEN_W),
    .QUO_WIDTH (QUO_W),
    .SB_W      (KIND_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (prep_valid_r),
    .in_num    (prep_num_r),
    .in_den    (prep_den_r),
    .in_sb     (KIND_W'(prep_kind_r)),
    .out_valid (div_valid),
    .out_quo   (div_quo),
    .out_rem   (),
    .out_sb    (div_sb)
  );

  assign div_kind = gew_kind_t'(div_sb);

  // Table read stage. Triangle and rectangle gains are settled here too.
  logic [GAIN_W-1:0] rom_data;

  gew_gauss_rom #(
    .DEPTH  (GAUSS_TABLE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_rom (
    .clk     (clk),
    .en      (en),
    .rd_addr (div_quo[IDX_W-1:0]),
    .rd_data (rom_data)
  );

  logic              p1_valid_r;
  logic [QUO_W-1:0]  p1_q_r;
  gew_kind_t         p1_kind_r;
  logic [GAIN_W-1:0] p1_lin_r, p1_lin_nxt;

  always_comb begin
    unique case (div_kind)
      KIND_TRI:  p1_lin_nxt = div_quo[GAIN_W-1:0];
      KIND_RECT: p1_lin_nxt = GAIN_ONE;
      default:   p1_lin_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_q_r    <= div_quo;
      p1_kind_r <= div_kind;
      p1_lin_r  <= p1_lin_nxt;
    end
  end

  // Fifth power chain. Beats of the other shapes carry their gain in the sideband.
  logic                pow_in_use;
  logic [GAIN_W-1:0]   pow_in_lin;
  logic                pow_valid;
  logic [GAIN_W-1:0]   pow_gain;
  logic [POW_SB_W-1:0] pow_sb;

  assign pow_in_use = (p1_kind_r == KIND_POW);
  assign pow_in_lin = (p1_kind_r == KIND_GAUSS) ? rom_data : p1_lin_r;

  gew_pow5 #(
    .SB_W (POW_SB_W)
  ) u_pow5 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p1_valid_r),
    .in_q      (p1_q_r),
    .in_sb     ({pow_in_use, pow_in_lin}),
    .out_valid (pow_valid),
    .out_gain  (pow_gain),
    .out_sb    (pow_sb)
  );

  logic [GAIN_W-1:0] fin_gain;

  assign fin_gain = pow_sb[GAIN_W] ? pow_gain : pow_sb[GAIN_W-1:0];

  // Output register with a skid register behind it. The pipeline only moves
  // while the skid register is empty, so a finished beat always has a place.
  logic              out_valid_r, out_valid_nxt;
  logic [GAIN_W-1:0] out_gain_r, out_gain_nxt;
  logic [GAIN_W-1:0] skid_gain_r, skid_gain_nxt;
  logic              out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_gain_nxt   = out_gain_r;
    skid_valid_nxt = skid_valid_r;
    skid_gain_nxt  = skid_gain_r;
    if (skid_valid_r) begin
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_gain_nxt   = skid_gain_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (pow_valid) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_gain_nxt  = fin_gain;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_gain_nxt  = fin_gain;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_gain_r  <= out_gain_nxt;
    skid_gain_r <= skid_gain_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_gain  = out_gain_r;

  // A beat in the skid register always has one ahead of it in the output register.
  `GEW_ASSERT(a_skid_behind_out, skid_valid_r |-> out_valid_r)
  // A finished beat that meets a held output register lands in the skid register.
  `GEW_ASSERT_NXT(a_skid_catches, pow_valid && !skid_valid_r && out_valid_r && out_stall,
                  skid_valid_r)
  // Once the output beat is taken, the skid beat moves up.
  `GEW_ASSERT_NXT(a_skid_drains, skid_valid_r && !out_stall, !skid_valid_r && out_valid_r)
  // No shape ever produces more than unity gain.
  `GEW_ASSERT(a_gain_range, out_valid_r |-> (out_gain_r <= GAIN_ONE))

endmodule
